FILE: hw/rtl/cra_pkg.sv
// Shared constants, codes, command/status structs and helpers for the cell allocator.
package cra_pkg;

  // Sizing
  localparam int NUM_CELLS  = 4095;
  localparam int COUNT_BITS = 16;
  localparam int IDX_W      = 12;
  localparam int DEPTH      = 1 << IDX_W;
  localparam int FUNC_W     = 3;
  localparam int TAG_W      = 4;
  localparam int STATUS_W   = 3;
  localparam int REFC_W     = 16;
  localparam int CFG_AW     = 3;
  localparam int CFG_DW     = 32;

  // Operation codes
  localparam logic [FUNC_W-1:0] FN_ALLOC   = 3'd0;
  localparam logic [FUNC_W-1:0] FN_FREE    = 3'd1;
  localparam logic [FUNC_W-1:0] FN_RETAIN  = 3'd2;
  localparam logic [FUNC_W-1:0] FN_RELEASE = 3'd3;
  localparam logic [FUNC_W-1:0] FN_DELETE  = 3'd4;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_OOM     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_RC_ERR  = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_ALC = 3'd3;
  localparam logic [STATUS_W-1:0] ST_IGNORED = 3'd4;

  // Type tags
  localparam logic [TAG_W-1:0] TAG_FIRST_REF = 4'd3;
  localparam logic [TAG_W-1:0] TAG_HASH_PAIR = 4'd7;

  // Register indexes
  localparam logic REG_TOTAL_CELLS = 1'b0;

  localparam logic [IDX_W-1:0]      IDX_NULL  = '0;
  localparam logic [IDX_W-1:0]      IDX_FIRST = IDX_W'(1);
  localparam logic [IDX_W-1:0]      IDX_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] CNT_MAX   = '1;
  localparam logic [COUNT_BITS-1:0] CNT_ONE   = COUNT_BITS'(1);

  // Controller to datapath commands
  typedef struct packed {
    logic init;   // restart list, heap use and count clearing
    logic clear;  // one clearing step
    logic issue;  // capture a beat and launch table reads
    logic exec;   // resolve the operation, write back, drive result
  } ctrl_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic clear_last;
  } dp_status_t;

  // Register value limited to the cells the tables can hold
  function automatic logic [IDX_W-1:0] clamp_total(input logic [IDX_W-1:0] v);
    logic [IDX_W-1:0] res;
    res = v;
    if (int'(v) > NUM_CELLS) res = IDX_W'(NUM_CELLS);
    return res;
  endfunction

endpackage

FILE: hw/rtl/cra_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cra_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

endmodule

FILE: hw/rtl/cra_ctrl.sv
// Controller state machine: clearing pass, idle, and one execute step per beat.
module cra_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic                cfg_wr,
  input  cra_pkg::dp_status_t sts,
  output cra_pkg::ctrl_cmd_t  cmd,
  output logic                busy
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   busy_r, busy_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR: if (sts.clear_last) state_nxt = S_IDLE;
      S_IDLE:  if (start)          state_nxt = S_EXEC;
      S_EXEC:                      state_nxt = S_IDLE;
      default:                     state_nxt = S_CLEAR;
    endcase
    if (cfg_wr) state_nxt = S_CLEAR;
    busy_nxt = (state_nxt != S_IDLE);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      busy_r  <= 1'b1;
    end else begin
      state_r <= state_nxt;
      busy_r  <= busy_nxt;
    end
  end

  // Commands
  assign cmd.init  = cfg_wr;
  assign cmd.clear = (state_r == S_CLEAR);
  assign cmd.issue = start && !busy_r;
  assign cmd.exec  = (state_r == S_EXEC);
  assign busy      = busy_r;

`ifndef SYNTH
  a_init_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_wr |=> busy_r && state_r == S_CLEAR)
    else $error("config write did not start a clearing pass");

  a_exec_after_issue: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.issue && !cfg_wr |=> state_r == S_EXEC)
    else $error("accepted beat did not reach execute");

  a_busy_tracks_state: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r == (state_r != S_IDLE))
    else $error("busy does not match the controller state");
`endif

endmodule

FILE: hw/rtl/cra_datapath.sv
// Datapath: free-list head, heap use, link/chunk/count tables and result registers.
module cra_datapath (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cra_pkg::ctrl_cmd_t                  cmd,
  output cra_pkg::dp_status_t                 sts,
  input  logic [cra_pkg::FUNC_W-1:0]          in_func,
  input  logic [cra_pkg::IDX_W-1:0]           in_cell_req,
  input  logic [cra_pkg::TAG_W-1:0]           in_type_tag,
  input  logic [cra_pkg::IDX_W-1:0]           total_cells,
  output logic                                out_valid,
  output logic [cra_pkg::IDX_W-1:0]           out_cell_out,
  output logic [cra_pkg::STATUS_W-1:0]        out_status,
  output logic [cra_pkg::REFC_W-1:0]          out_ref_count,
  output logic [cra_pkg::IDX_W-1:0]           out_free_cells
);

  localparam int IW = cra_pkg::IDX_W;
  localparam int CW = cra_pkg::COUNT_BITS;

  // Control registers
  logic [IW-1:0] free_head_r, free_head_nxt;
  logic [IW-1:0] heap_r, heap_nxt;
  logic [IW-1:0] clr_cnt_r;
  logic          out_valid_r;

  // Captured beat
  logic [cra_pkg::FUNC_W-1:0] func_r;
  logic [IW-1:0]              cell_r;
  logic [cra_pkg::TAG_W-1:0]  tag_r;

  // Result registers
  logic [IW-1:0]                cout_r, cout_nxt;
  logic [cra_pkg::STATUS_W-1:0] st_r, st_nxt;
  logic [CW-1:0]                rc_r, rc_nxt;
  logic [IW-1:0]                fc_r, fc_nxt;

  // Table ports
  logic          link_we, chunk_we, cnt_we;
  logic [IW-1:0] link_wa, chunk_wa, cnt_wa;
  logic [IW-1:0] link_wd, chunk_wd;
  logic [CW-1:0] cnt_wd;
  logic [IW-1:0] link_rd, chunk_rd;
  logic [CW-1:0] cnt_rd;

  // Execute step signals
  logic          x_link_we, x_chunk_we, x_cnt_we;
  logic [IW-1:0] x_link_wa, x_chunk_wa, x_cnt_wa;
  logic [IW-1:0] x_link_wd, x_chunk_wd;
  logic [CW-1:0] x_cnt_wd;
  logic [IW-1:0] alloc_cell;

  cra_ram #(.WIDTH(IW), .DEPTH(cra_pkg::DEPTH)) u_link (
    .clk, .we(link_we), .waddr(link_wa), .wdata(link_wd),
    .raddr(free_head_r), .rdata(link_rd)
  );

  cra_ram #(.WIDTH(IW), .DEPTH(cra_pkg::DEPTH)) u_chunk (
    .clk, .we(chunk_we), .waddr(chunk_wa), .wdata(chunk_wd),
    .raddr(free_head_r), .rdata(chunk_rd)
  );

  cra_ram #(.WIDTH(CW), .DEPTH(cra_pkg::DEPTH)) u_count (
    .clk, .we(cnt_we), .waddr(cnt_wa), .wdata(cnt_wd),
    .raddr(in_cell_req), .rdata(cnt_rd)
  );

  assign sts.clear_last = (clr_cnt_r == cra_pkg::IDX_MAX);

  // Operation resolve: reads from the issue cycle are valid here
  always_comb begin
    x_link_we     = 1'b0;
    x_chunk_we    = 1'b0;
    x_cnt_we      = 1'b0;
    x_link_wa     = cell_r;
    x_chunk_wa    = cell_r;
    x_cnt_wa      = cell_r;
    x_link_wd     = free_head_r;
    x_chunk_wd    = IW'(1);
    x_cnt_wd      = '0;
    free_head_nxt = free_head_r;
    heap_nxt      = heap_r;
    cout_nxt      = cra_pkg::IDX_NULL;
    st_nxt        = cra_pkg::ST_IGNORED;
    rc_nxt        = '0;
    alloc_cell    = free_head_r + chunk_rd - IW'(1);

    case (func_r)
      cra_pkg::FN_ALLOC: begin
        if (free_head_r == cra_pkg::IDX_NULL || chunk_rd == '0) begin
          st_nxt = cra_pkg::ST_OOM;
        end else begin
          if (chunk_rd == IW'(1)) begin
            free_head_nxt = link_rd;
            alloc_cell    = free_head_r;
          end else begin
            // carve the last cell off the head chunk
            x_chunk_we = 1'b1;
            x_chunk_wa = free_head_r;
            x_chunk_wd = chunk_rd - IW'(1);
          end
          if (link_rd == cra_pkg::IDX_NULL && heap_r != cra_pkg::IDX_MAX)
            heap_nxt = heap_r + IW'(1);
          x_cnt_we = 1'b1;
          x_cnt_wa = alloc_cell;
          x_cnt_wd = cra_pkg::CNT_ONE;
          cout_nxt = alloc_cell;
          st_nxt   = cra_pkg::ST_OK;
          rc_nxt   = cra_pkg::CNT_ONE;
        end
      end
      cra_pkg::FN_FREE, cra_pkg::FN_RETAIN, cra_pkg::FN_RELEASE, cra_pkg::FN_DELETE: begin
        if (cell_r == cra_pkg::IDX_NULL || tag_r < cra_pkg::TAG_FIRST_REF) begin
          cout_nxt = cell_r;
        end else begin
          case (func_r)
            cra_pkg::FN_FREE: begin
              if (cnt_rd == '0) begin
                st_nxt = cra_pkg::ST_NOT_ALC;
              end else begin
                // push as a one-cell chunk
                x_link_we     = 1'b1;
                x_chunk_we    = 1'b1;
                x_cnt_we      = 1'b1;
                free_head_nxt = cell_r;
                cout_nxt      = cell_r;
                st_nxt        = cra_pkg::ST_OK;
              end
            end
            cra_pkg::FN_RETAIN: begin
              x_cnt_we = 1'b1;
              x_cnt_wd = (cnt_rd == cra_pkg::CNT_MAX) ? cnt_rd : cnt_rd + CW'(1);
              cout_nxt = cell_r;
              st_nxt   = cra_pkg::ST_OK;
              rc_nxt   = x_cnt_wd;
            end
            cra_pkg::FN_RELEASE: begin
              if (cnt_rd <= cra_pkg::CNT_ONE) begin
                st_nxt = cra_pkg::ST_RC_ERR;
                rc_nxt = cnt_rd;
              end else begin
                x_cnt_we = 1'b1;
                x_cnt_wd = cnt_rd - CW'(1);
                cout_nxt = cell_r;
                st_nxt   = cra_pkg::ST_OK;
                rc_nxt   = x_cnt_wd;
              end
            end
            default: begin
              // delete
              if (cnt_rd == '0) begin
                st_nxt = cra_pkg::ST_NOT_ALC;
              end else if (cnt_rd != cra_pkg::CNT_ONE) begin
                st_nxt = cra_pkg::ST_RC_ERR;
                rc_nxt = cnt_rd;
              end else begin
                x_cnt_we = 1'b1;
                if (tag_r != cra_pkg::TAG_HASH_PAIR) begin
                  x_link_we     = 1'b1;
                  x_chunk_we    = 1'b1;
                  free_head_nxt = cell_r;
                end
                cout_nxt = cell_r;
                st_nxt   = cra_pkg::ST_OK;
              end
            end
          endcase
        end
      end
      default: ;
    endcase

    fc_nxt = (total_cells > heap_nxt) ? total_cells - heap_nxt : '0;
  end

  // Table write select: clearing pass or execute step
  always_comb begin
    if (cmd.clear) begin
      link_we  = 1'b1;
      link_wa  = cra_pkg::IDX_FIRST;
      link_wd  = cra_pkg::IDX_NULL;
      chunk_we = 1'b1;
      chunk_wa = cra_pkg::IDX_FIRST;
      chunk_wd = total_cells;
      cnt_we   = 1'b1;
      cnt_wa   = clr_cnt_r;
      cnt_wd   = '0;
    end else begin
      link_we  = cmd.exec && x_link_we;
      link_wa  = x_link_wa;
      link_wd  = x_link_wd;
      chunk_we = cmd.exec && x_chunk_we;
      chunk_wa = x_chunk_wa;
      chunk_wd = x_chunk_wd;
      cnt_we   = cmd.exec && x_cnt_we;
      cnt_wa   = x_cnt_wa;
      cnt_wd   = x_cnt_wd;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n || cmd.init) begin
      free_head_r <= cra_pkg::IDX_FIRST;
      heap_r      <= '0;
      clr_cnt_r   <= '0;
    end else begin
      if (cmd.clear) clr_cnt_r <= clr_cnt_r + IW'(1);
      if (cmd.exec) begin
        free_head_r <= free_head_nxt;
        heap_r      <= heap_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= cmd.exec;
  end

  // Beat capture and result payload
  always_ff @(posedge clk) begin
    if (cmd.issue) begin
      func_r <= in_func;
      cell_r <= in_cell_req;
      tag_r  <= in_type_tag;
    end
    if (cmd.exec) begin
      cout_r <= cout_nxt;
      st_r   <= st_nxt;
      rc_r   <= rc_nxt;
      fc_r   <= fc_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_cell_out   = cout_r;
  assign out_status     = st_r;
  assign out_ref_count  = cra_pkg::REFC_W'(rc_r);
  assign out_free_cells = fc_r;

`ifndef SYNTH
  a_strobe_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> $past(cmd.exec))
    else $error("result strobe without an execute step");

  a_heap_monotone: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.init |=> heap_r >= $past(heap_r))
    else $error("heap use went down without a reinitialise");

  a_clear_counter_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !cmd.clear && !cmd.init |=> $stable(clr_cnt_r))
    else $error("clear counter moved outside a clearing pass");
`endif

endmodule

FILE: hw/rtl/cell_allocator_refcount.sv
// Top level: fixed-size cell allocator with reference counts and its register port.
//
// Usage
//   Commands: drive in_func, in_cell_req and in_type_tag with start high; the
//   beat is taken at a rising edge where start is high and busy is low.
//   Results: out_valid pulses for one cycle with out_cell_out, out_status,
//   out_ref_count and out_free_cells; the receiver cannot stall, so every
//   result is taken in that cycle.
//   Flow: busy is high from the accepting edge through the execute step, so a
//   new command is taken only after the last one is resolved; the registered read of
//   the link, chunk and count tables is followed by the resolve/write-back step.
//   Registers: total_cells at byte address 0 over the APB-style port; pready is
//   always high. Writing it rebuilds the free list as one chunk at cell 1.
//   Reset and every total_cells write start a clearing pass over all 4096
//   count table entries, one a cycle, with busy high. Commands are taken
//   once busy falls. Write the register only while no command is in flight.
module cell_allocator_refcount (
  input  logic                                clk,
  input  logic                                rst_n,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [cra_pkg::FUNC_W-1:0]          in_func,
  input  logic [cra_pkg::IDX_W-1:0]           in_cell_req,
  input  logic [cra_pkg::TAG_W-1:0]           in_type_tag,
  // result channel
  output logic                                out_valid,
  output logic [cra_pkg::IDX_W-1:0]           out_cell_out,
  output logic [cra_pkg::STATUS_W-1:0]        out_status,
  output logic [cra_pkg::REFC_W-1:0]          out_ref_count,
  output logic [cra_pkg::IDX_W-1:0]           out_free_cells,
  // register port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [cra_pkg::CFG_AW-1:0]          paddr,
  input  logic [cra_pkg::CFG_DW-1:0]          pwdata,
  output logic [cra_pkg::CFG_DW-1:0]          prdata,
  output logic                                pready
);

  logic [cra_pkg::IDX_W-1:0] total_cells_r;
  logic                      reg_sel;
  logic                      total_wr;
  cra_pkg::ctrl_cmd_t        cmd;
  cra_pkg::dp_status_t       sts;

  // Register decode: one word per register
  assign pready   = 1'b1;
  assign reg_sel  = paddr[cra_pkg::CFG_AW-1];
  assign total_wr = psel && penable && pwrite && pready &&
                    (reg_sel == cra_pkg::REG_TOTAL_CELLS);
  assign prdata   = (reg_sel == cra_pkg::REG_TOTAL_CELLS) ?
                    cra_pkg::CFG_DW'(total_cells_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n)        total_cells_r <= cra_pkg::IDX_MAX;
    else if (total_wr) total_cells_r <= cra_pkg::clamp_total(pwdata[cra_pkg::IDX_W-1:0]);
  end

  cra_ctrl u_ctrl (
    .clk,
    .rst_n,
    .start,
    .cfg_wr (total_wr),
    .sts,
    .cmd,
    .busy
  );

  cra_datapath u_dp (
    .clk,
    .rst_n,
    .cmd,
    .sts,
    .in_func,
    .in_cell_req,
    .in_type_tag,
    .total_cells (total_cells_r),
    .out_valid,
    .out_cell_out,
    .out_status,
    .out_ref_count,
    .out_free_cells
  );

endmodule
